// ===== hw/rtl/rqi_pkg.sv =====
// Shared types, constants and saturating helpers of the ray-quadric intersection unit.
package rqi_pkg;

  // One ray beat.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] near_limit;
    logic signed [31:0] far_limit;
  } ray_in_t;

  // One result beat.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic               root_taken;
  } ray_res_t;

  typedef logic signed [63:0] wide_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CFG   = 5;
  localparam logic [CFG_IDX_W-1:0] REG_XX_YY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZZ_XY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XZ_YZ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CONST  = 3'd4;

  // Register reset values.
  localparam logic [63:0] RST_XX_YY   = 64'h0001_0000_0001_0000;
  localparam logic [63:0] RST_ZZ_XY   = 64'h0001_0000_0000_0000;
  localparam logic [63:0] RST_XZ_YZ   = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_X_Y     = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_Z_CONST = 64'h0000_0000_FFFF_0000;

  // Saturation limits of the wide intermediates.
  localparam wide_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t SAT_MIN = 64'sh8000_0000_0000_0000;

  // Pipeline depths of the shared units.
  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 3;
  localparam int unsigned NTERM     = 12;

  // Number of root bits, one pipeline stage each, for a positive 63-bit radicand.
  function automatic int unsigned sqrt_steps(input int unsigned frac);
    return (65 + frac) >> 1;
  endfunction

  // Saturating 64-bit add.
  function automatic wide_t sadd64(input wide_t x, input wide_t y);
    wide_t s;
    s = x + y;
    if (x[63] == y[63] && s[63] != x[63]) begin
      return x[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

  // Saturating 64-bit subtract.
  function automatic wide_t ssub64(input wide_t x, input wide_t y);
    wide_t s;
    s = x - y;
    if (x[63] != y[63] && s[63] != x[63]) begin
      return x[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/rqi_delay.sv =====
// Fixed-depth shift line that keeps side data aligned with the arithmetic units.
module rqi_delay import rqi_pkg::*; #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  // Shift one stage per cycle.
  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== hw/rtl/rqi_mulq.sv =====
// Pipelined signed fixed-point multiplier: floor shift by the fraction width, 64-bit saturation.
module rqi_mulq import rqi_pkg::*; #(
  parameter int unsigned AW        = 32,
  parameter int unsigned BW        = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output wide_t                p_o
);

  localparam int unsigned NA = AW / 32;
  localparam int unsigned NB = BW / 32;
  localparam int unsigned PW = AW + BW;
  localparam logic [PW-1:0] POS_LIM = PW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [PW-1:0] NEG_LIM = PW'(64'h8000_0000_0000_0000);

  logic [AW-1:0] ma_q;
  logic [BW-1:0] mb_q;
  logic          neg1_q, neg2_q, neg3_q;
  logic [63:0]   pp_q [NA][NB];
  logic [PW-1:0] sum_d, sum_q;
  logic [PW-1:0] shq, ceilq;
  wide_t         p_d, p_q;

  // Stage 1: magnitudes and product sign.
  always_ff @(posedge clk_i) begin
    ma_q   <= a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
    mb_q   <= b_i[BW-1] ? (~b_i + BW'(1)) : b_i;
    neg1_q <= a_i[AW-1] ^ b_i[BW-1];
  end

  // Stage 2: 32 by 32 partial products.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= 64'(ma_q[32*i +: 32]) * 64'(mb_q[32*j +: 32]);
      end
    end
    neg2_q <= neg1_q;
  end

  // Stage 3: combine partial products into the exact magnitude.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    neg3_q <= neg2_q;
  end

  // Stage 4: round toward minus infinity and saturate.
  always_comb begin
    shq   = sum_q >> FRAC_BITS;
    ceilq = shq + PW'(sum_q[FRAC_BITS-1:0] != '0);
    if (neg3_q) begin
      p_d = (ceilq > NEG_LIM) ? SAT_MIN : wide_t'(~ceilq[63:0] + 64'd1);
    end else begin
      p_d = (shq > POS_LIM) ? SAT_MAX : wide_t'(shq[63:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/rqi_sqrt.sv =====
// Pipelined integer square root of the discriminant scaled by the fraction, one root bit a stage.
module rqi_sqrt import rqi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  wide_t v_i,
  output wide_t r_o
);

  localparam int unsigned N  = sqrt_steps(FRAC_BITS);
  localparam int unsigned RW = 2 * N;

  logic [RW-1:0] rad_q  [N];
  logic [N+1:0]  rem_q  [N];
  logic [N-1:0]  root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] rad_in;
    logic [N+1:0]  rem_in;
    logic [N-1:0]  root_in;
    logic [N+1:0]  rem_n, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_in  = RW'(v_i) << FRAC_BITS;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down the next bit pair and try the trial divisor.
    always_comb begin
      rem_n = {rem_in[N-1:0], rad_in[RW-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = rem_n >= trial;
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? (rem_n - trial) : rem_n;
      root_q[k] <= {root_in[N-2:0], ge};
    end
  end

  assign r_o = wide_t'(64'(root_q[N-1]));

endmodule

// ===== hw/rtl/rqi_div.sv =====
// Pipelined restoring divider: (num << FRAC_BITS) / den toward zero, saturated to 32 bits.
module rqi_div import rqi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  wide_t              num_i,
  input  wide_t              den_i,
  output logic signed [31:0] q_o
);

  localparam int unsigned NW = 64 + FRAC_BITS;

  logic [63:0]     nm_q, dm_q, dm_b_q;
  logic            neg_a_q, neg_b_q, ovf_b_q;
  logic [63:0]     rem_b_q;
  logic [31:0]     low_b_q;
  logic [NW-1:0]   n_full;
  logic [63:0]     hi_part;

  logic [63:0]        rem_q  [DIV_STEPS];
  logic [31:0]        low_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];
  logic [63:0]        dm_s_q [DIV_STEPS];
  logic               neg_s_q [DIV_STEPS];
  logic               ovf_s_q [DIV_STEPS];

  logic signed [31:0] q_d, q_q;
  logic [31:0]        qf;

  // Stage A: magnitudes and quotient sign.
  always_ff @(posedge clk_i) begin
    nm_q    <= num_i[63] ? (~num_i + 64'd1) : num_i;
    dm_q    <= den_i[63] ? (~den_i + 64'd1) : den_i;
    neg_a_q <= num_i[63] ^ den_i[63];
  end

  // Stage B: quotient bits above 32 mean saturation; otherwise seed the remainder.
  always_comb begin
    n_full  = {nm_q, {FRAC_BITS{1'b0}}};
    hi_part = 64'(n_full[NW-1:32]);
  end

  always_ff @(posedge clk_i) begin
    ovf_b_q <= hi_part >= dm_q;
    rem_b_q <= hi_part;
    low_b_q <= n_full[31:0];
    dm_b_q  <= dm_q;
    neg_b_q <= neg_a_q;
  end

  // One quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0]          rem_in, dm_in;
    logic [31:0]          low_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic                 neg_in, ovf_in;
    logic [64:0]          rem_n;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_b_q;
      assign low_in = low_b_q;
      assign quo_in = '0;
      assign dm_in  = dm_b_q;
      assign neg_in = neg_b_q;
      assign ovf_in = ovf_b_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dm_in  = dm_s_q[k-1];
      assign neg_in = neg_s_q[k-1];
      assign ovf_in = ovf_s_q[k-1];
    end

    always_comb begin
      rem_n = {rem_in, low_in[31]};
      ge    = rem_n >= {1'b0, dm_in};
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]   <= ge ? 64'(rem_n - {1'b0, dm_in}) : rem_n[63:0];
      low_q[k]   <= low_in << 1;
      quo_q[k]   <= {quo_in[DIV_STEPS-2:0], ge};
      dm_s_q[k]  <= dm_in;
      neg_s_q[k] <= neg_in;
      ovf_s_q[k] <= ovf_in;
    end
  end

  // Final stage: apply the sign and saturate to 32 bits.
  always_comb begin
    qf = quo_q[DIV_STEPS-1];
    if (neg_s_q[DIV_STEPS-1]) begin
      q_d = (ovf_s_q[DIV_STEPS-1] || qf > 32'h8000_0000) ? 32'sh8000_0000
                                                          : $signed(~qf + 32'd1);
    end else begin
      q_d = (ovf_s_q[DIV_STEPS-1] || qf > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

// ===== hw/rtl/ray_quadric_intersect_unit.sv =====
// Each accepted ray gives a result strobe on done_o, with its result beat on res_o.
// Throughput: one ray per cycle while busy is low; the feed-forward multiplier, root and divider pipelines set it.
// The square root takes one stage per root bit and each divider one stage per quotient bit.
// Reset clears the valid bits, sets the busy flag and sets the coefficients to a unit sphere.
// The block raises busy only during and just after reset; results are never held back.
module ray_quadric_intersect_unit import rqi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ray_in_t              ray_i,
  output logic                 done_o,
  output ray_res_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned SQ_LAT  = sqrt_steps(FRAC_BITS);
  localparam int unsigned S_PREP  = 2 * MUL_LAT + 1;
  localparam int unsigned S_FOLD  = S_PREP + NTERM - 1;
  localparam int unsigned S_D2    = S_FOLD + MUL_LAT + 2;
  localparam int unsigned S_E     = S_D2 + SQ_LAT + 1;
  localparam int unsigned S_DV    = S_E + DIV_LAT;
  localparam int unsigned OUT_LAT = S_DV + 2;

  localparam int unsigned N_L1 = 27;
  localparam int unsigned N_L2 = 21;

  // Configuration registers.
  logic [63:0] cfg_q [NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_XX_YY]   <= RST_XX_YY;
      cfg_q[REG_ZZ_XY]   <= RST_ZZ_XY;
      cfg_q[REG_XZ_YZ]   <= RST_XZ_YZ;
      cfg_q[REG_X_Y]     <= RST_X_Y;
      cfg_q[REG_Z_CONST] <= RST_Z_CONST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_XX_YY:   cfg_q[REG_XX_YY]   <= cfg_data_i;
        REG_ZZ_XY:   cfg_q[REG_ZZ_XY]   <= cfg_data_i;
        REG_XZ_YZ:   cfg_q[REG_XZ_YZ]   <= cfg_data_i;
        REG_X_Y:     cfg_q[REG_X_Y]     <= cfg_data_i;
        REG_Z_CONST: cfg_q[REG_Z_CONST] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic signed [31:0] cxx, cyy, czz, cxy, cxz, cyz, cx, cy, cz, c0;
  assign cxx = cfg_q[REG_XX_YY][63:32];
  assign cyy = cfg_q[REG_XX_YY][31:0];
  assign czz = cfg_q[REG_ZZ_XY][63:32];
  assign cxy = cfg_q[REG_ZZ_XY][31:0];
  assign cxz = cfg_q[REG_XZ_YZ][63:32];
  assign cyz = cfg_q[REG_XZ_YZ][31:0];
  assign cx  = cfg_q[REG_X_Y][63:32];
  assign cy  = cfg_q[REG_X_Y][31:0];
  assign cz  = cfg_q[REG_Z_CONST][63:32];
  assign c0  = cfg_q[REG_Z_CONST][31:0];

  // Input beat register, busy flag and the valid line of the pipeline.
  logic            busy_q;
  logic            accept;
  ray_in_t         in_q;
  logic [S_DV:0]   vld_q;
  logic            done_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[S_DV-1:0], accept};
      done_q <= vld_q[S_DV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= ray_i;
    end
  end

  // First multiplier level: coordinate products and linear terms.
  logic signed [31:0] l1_x [N_L1];
  logic signed [31:0] l1_y [N_L1];
  wide_t              l1_p [N_L1];

  always_comb begin
    l1_x[0]  = in_q.dir_x;    l1_y[0]  = in_q.dir_x;
    l1_x[1]  = in_q.dir_y;    l1_y[1]  = in_q.dir_y;
    l1_x[2]  = in_q.dir_z;    l1_y[2]  = in_q.dir_z;
    l1_x[3]  = in_q.dir_x;    l1_y[3]  = in_q.dir_y;
    l1_x[4]  = in_q.dir_x;    l1_y[4]  = in_q.dir_z;
    l1_x[5]  = in_q.dir_y;    l1_y[5]  = in_q.dir_z;
    l1_x[6]  = in_q.dir_x;    l1_y[6]  = in_q.origin_x;
    l1_x[7]  = in_q.dir_y;    l1_y[7]  = in_q.origin_y;
    l1_x[8]  = in_q.dir_z;    l1_y[8]  = in_q.origin_z;
    l1_x[9]  = in_q.dir_x;    l1_y[9]  = in_q.origin_y;
    l1_x[10] = in_q.dir_y;    l1_y[10] = in_q.origin_x;
    l1_x[11] = in_q.dir_x;    l1_y[11] = in_q.origin_z;
    l1_x[12] = in_q.dir_z;    l1_y[12] = in_q.origin_x;
    l1_x[13] = in_q.dir_y;    l1_y[13] = in_q.origin_z;
    l1_x[14] = in_q.dir_z;    l1_y[14] = in_q.origin_y;
    l1_x[15] = in_q.origin_x; l1_y[15] = in_q.origin_x;
    l1_x[16] = in_q.origin_y; l1_y[16] = in_q.origin_y;
    l1_x[17] = in_q.origin_z; l1_y[17] = in_q.origin_z;
    l1_x[18] = in_q.origin_x; l1_y[18] = in_q.origin_y;
    l1_x[19] = in_q.origin_x; l1_y[19] = in_q.origin_z;
    l1_x[20] = in_q.origin_y; l1_y[20] = in_q.origin_z;
    l1_x[21] = cx;            l1_y[21] = in_q.dir_x;
    l1_x[22] = cy;            l1_y[22] = in_q.dir_y;
    l1_x[23] = cz;            l1_y[23] = in_q.dir_z;
    l1_x[24] = cx;            l1_y[24] = in_q.origin_x;
    l1_x[25] = cy;            l1_y[25] = in_q.origin_y;
    l1_x[26] = cz;            l1_y[26] = in_q.origin_z;
  end

  for (genvar i = 0; i < N_L1; i++) begin : g_l1
    rqi_mulq #(.AW(32), .BW(32), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clk_i (clk_i),
      .a_i   (l1_x[i]),
      .b_i   (l1_y[i]),
      .p_o   (l1_p[i])
    );
  end

  // Second multiplier level: quadric coefficients times coordinate products.
  logic signed [31:0] l2_c [N_L2];
  wide_t              l2_p [N_L2];

  always_comb begin
    l2_c[0]  = cxx; l2_c[1]  = cyy; l2_c[2]  = czz;
    l2_c[3]  = cxy; l2_c[4]  = cxz; l2_c[5]  = cyz;
    l2_c[6]  = cxx; l2_c[7]  = cyy; l2_c[8]  = czz;
    l2_c[9]  = cxy; l2_c[10] = cxy; l2_c[11] = cxz;
    l2_c[12] = cxz; l2_c[13] = cyz; l2_c[14] = cyz;
    l2_c[15] = cxx; l2_c[16] = cyy; l2_c[17] = czz;
    l2_c[18] = cxy; l2_c[19] = cxz; l2_c[20] = cyz;
  end

  for (genvar i = 0; i < N_L2; i++) begin : g_l2
    rqi_mulq #(.AW(32), .BW(64), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clk_i (clk_i),
      .a_i   (l2_c[i]),
      .b_i   (l1_p[i]),
      .p_o   (l2_p[i])
    );
  end

  // Linear terms wait for the second level.
  logic [6*64-1:0] lin_d, lin_q;
  assign lin_d = {l1_p[26], l1_p[25], l1_p[24], l1_p[23], l1_p[22], l1_p[21]};

  rqi_delay #(.W(6*64), .DEPTH(MUL_LAT)) u_lin_dly (
    .clk_i (clk_i),
    .d_i   (lin_d),
    .q_o   (lin_q)
  );

  // Term lists for a, b and c; the fold adds them in order with saturation.
  wide_t acc_q [NTERM][3];
  wide_t trm_q [NTERM][3][NTERM];
  wide_t trm_d [3][NTERM];
  wide_t lin [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      lin[j] = wide_t'(lin_q[64*j +: 64]);
    end
    for (int j = 0; j < NTERM; j++) begin
      trm_d[0][j] = '0;
      trm_d[1][j] = '0;
      trm_d[2][j] = '0;
    end
    for (int j = 0; j < 6; j++) begin
      trm_d[0][j] = l2_p[j];
      trm_d[2][j] = l2_p[15+j];
    end
    trm_d[1][0] = sadd64(l2_p[6], l2_p[6]);
    trm_d[1][1] = sadd64(l2_p[7], l2_p[7]);
    trm_d[1][2] = sadd64(l2_p[8], l2_p[8]);
    for (int j = 3; j < 9; j++) begin
      trm_d[1][j] = l2_p[6+j];
    end
    trm_d[1][9]  = lin[0];
    trm_d[1][10] = lin[1];
    trm_d[1][11] = lin[2];
    trm_d[2][6]  = lin[3];
    trm_d[2][7]  = lin[4];
    trm_d[2][8]  = lin[5];
    trm_d[2][9]  = wide_t'(64'(c0));
  end

  always_ff @(posedge clk_i) begin
    trm_q[0] <= trm_d;
    for (int s = 0; s < 3; s++) begin
      acc_q[0][s] <= trm_d[s][0];
    end
  end

  // One saturating add per stage.
  for (genvar k = 1; k < NTERM; k++) begin : g_fold
    always_ff @(posedge clk_i) begin
      trm_q[k] <= trm_q[k-1];
      for (int s = 0; s < 3; s++) begin
        acc_q[k][s] <= sadd64(acc_q[k-1][s], trm_q[k-1][s][k]);
      end
    end
  end

  wide_t a_f, b_f, c_f;
  assign a_f = acc_q[NTERM-1][0];
  assign b_f = acc_q[NTERM-1][1];
  assign c_f = acc_q[NTERM-1][2];

  // Discriminant products.
  wide_t ac_p, bb_p;
  logic [127:0] ab_q;

  rqi_mulq #(.AW(64), .BW(64), .FRAC_BITS(FRAC_BITS)) u_mul_ac (
    .clk_i (clk_i),
    .a_i   (a_f),
    .b_i   (c_f),
    .p_o   (ac_p)
  );

  rqi_mulq #(.AW(64), .BW(64), .FRAC_BITS(FRAC_BITS)) u_mul_bb (
    .clk_i (clk_i),
    .a_i   (b_f),
    .b_i   (b_f),
    .p_o   (bb_p)
  );

  rqi_delay #(.W(128), .DEPTH(MUL_LAT)) u_ab_dly (
    .clk_i (clk_i),
    .d_i   ({a_f, b_f}),
    .q_o   (ab_q)
  );

  // Four a c, minus b, twice a and the a-not-zero flag.
  wide_t ac4_q, bb_q, nb1_q, den1_q;
  logic  anz1_q;
  wide_t ac2;

  always_comb begin
    ac2 = sadd64(ac_p, ac_p);
  end

  always_ff @(posedge clk_i) begin
    ac4_q  <= sadd64(ac2, ac2);
    bb_q   <= bb_p;
    nb1_q  <= ssub64('0, wide_t'(ab_q[63:0]));
    den1_q <= sadd64(wide_t'(ab_q[127:64]), wide_t'(ab_q[127:64]));
    anz1_q <= ab_q[127:64] != '0;
  end

  // Discriminant and the root condition.
  wide_t disc_q, nb2_q, den2_q;
  logic  ok2_q;
  wide_t disc_d;

  assign disc_d = ssub64(bb_q, ac4_q);

  always_ff @(posedge clk_i) begin
    disc_q <= disc_d;
    nb2_q  <= nb1_q;
    den2_q <= den1_q;
    ok2_q  <= anz1_q && !disc_d[63] && disc_d != '0;
  end

  // Square root and its side data.
  wide_t        sq_r;
  logic [128:0] sq_side;

  rqi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i (clk_i),
    .v_i   (disc_q),
    .r_o   (sq_r)
  );

  rqi_delay #(.W(129), .DEPTH(SQ_LAT)) u_sq_dly (
    .clk_i (clk_i),
    .d_i   ({ok2_q, nb2_q, den2_q}),
    .q_o   (sq_side)
  );

  // Numerators of both roots.
  wide_t num_p_q, num_m_q, den_e_q;
  logic  ok_e_q;

  always_ff @(posedge clk_i) begin
    num_p_q <= sadd64(wide_t'(sq_side[127:64]), sq_r);
    num_m_q <= ssub64(wide_t'(sq_side[127:64]), sq_r);
    den_e_q <= wide_t'(sq_side[63:0]);
    ok_e_q  <= sq_side[128];
  end

  // Both roots are divided side by side.
  logic signed [31:0] t_p, t_m;
  logic               ok_dv;

  rqi_div #(.FRAC_BITS(FRAC_BITS)) u_div_p (
    .clk_i (clk_i),
    .num_i (num_p_q),
    .den_i (den_e_q),
    .q_o   (t_p)
  );

  rqi_div #(.FRAC_BITS(FRAC_BITS)) u_div_m (
    .clk_i (clk_i),
    .num_i (num_m_q),
    .den_i (den_e_q),
    .q_o   (t_m)
  );

  rqi_delay #(.W(1), .DEPTH(DIV_LAT)) u_ok_dly (
    .clk_i (clk_i),
    .d_i   (ok_e_q),
    .q_o   (ok_dv)
  );

  // Window limits travel the whole pipeline.
  logic [63:0]        win_q;
  logic signed [31:0] near_w, far_w;

  rqi_delay #(.W(64), .DEPTH(S_DV)) u_win_dly (
    .clk_i (clk_i),
    .d_i   ({in_q.near_limit, in_q.far_limit}),
    .q_o   (win_q)
  );

  assign near_w = win_q[63:32];
  assign far_w  = win_q[31:0];

  // Root selection: the plus root wins when both lie in the window.
  logic     hit_p, hit_m;
  ray_res_t res_d, res_q;

  always_comb begin
    hit_p = ok_dv && t_p >= near_w && t_p <= far_w;
    hit_m = ok_dv && t_m >= near_w && t_m <= far_w;
    res_d.hit        = hit_p || hit_m;
    res_d.root_taken = !hit_p && hit_m;
    if (hit_p) begin
      res_d.distance = t_p;
    end else if (hit_m) begin
      res_d.distance = t_m;
    end else begin
      res_d.distance = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every accepted ray produces its result beat after the fixed latency.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##OUT_LAT done_o)
    else $error("accepted ray gave no result beat");

  // No result beat appears without an accepted ray.
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, OUT_LAT))
    else $error("result beat without an accepted ray");

  // A miss carries zero distance and the plus-root code.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.hit |-> res_o.distance == '0 && !res_o.root_taken)
    else $error("miss with nonzero payload");

endmodule
